@@ hdl/dfpq_pkg.sv @@
`default_nettype none
package dfpq_pkg;

	localparam int TYPE_W = 6;
	localparam int PRI_W  = 6;
	localparam int DIR_W  = 3;
	localparam int STAT_W = 2;

	localparam logic [DIR_W-1:0] DIR_NONE = 3'd6;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// storage update broadcast to every slot cell
	typedef struct packed {
		logic append;
		logic remove;
	} slot_ctl_t;

endpackage
`default_nettype wire

@@ hdl/direction_filtered_priority_queue.sv @@
`default_nettype none
// Ordered buffer of SLOTS items held in a row of slot cells. A command (add or
// select) is accepted only while the block is idle. Its result is loaded after a
// registered search wave has walked the cell row from the oldest slot to the newest
// (best match and per-direction count) in the scan state; the done state then
// appends or removes and compacts and loads the result register. The block then
// returns to idle, where it takes the next beat. One command is worked at a time; a
// new beat is accepted while the previous result still waits on out_stall, and that
// command's finishing cycle is held until the waiting result is taken.
module direction_filtered_priority_queue #(
	parameter int SLOTS    = 8,
	parameter int TAG_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          command,
	input  wire [dfpq_pkg::TYPE_W-1:0]   good_type,
	input  wire [dfpq_pkg::PRI_W-1:0]    priority_req,
	input  wire [dfpq_pkg::DIR_W-1:0]    direction,
	input  wire [TAG_BITS-1:0]           item_tag,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [dfpq_pkg::STAT_W-1:0]  status,
	output logic                         found,
	output logic [dfpq_pkg::TYPE_W-1:0]  out_good_type,
	output logic [TAG_BITS-1:0]          out_item_tag,
	output logic [dfpq_pkg::DIR_W-1:0]   notify_direction,
	output logic [$clog2(SLOTS+1)-1:0]   count_for_direction,
	output logic [$clog2(SLOTS+1)-1:0]   occupancy
);
	import dfpq_pkg::*;

	localparam int CNT_W = $clog2(SLOTS+1);
	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	state_t state_q, state_d;

	logic             cmd_q;
	logic [TYPE_W-1:0] type_q;
	logic [PRI_W-1:0]  pri_q;
	logic [DIR_W-1:0]  dir_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [IDX_W-1:0]  scan_q;
	logic [CNT_W-1:0]  fill_q;

	logic accept;
	logic scan_last;
	logic out_free;
	logic finish;

	slot_ctl_t ctl;

	// chain links, index 0 feeds the first cell, index SLOTS leaves the last
	logic              w_have [SLOTS+1];
	logic [PRI_W-1:0]  w_pri  [SLOTS+1];
	logic [IDX_W-1:0]  w_idx  [SLOTS+1];
	logic [CNT_W-1:0]  w_cnt  [SLOTS+1];
	logic [TYPE_W-1:0] w_type [SLOTS+1];
	logic [TAG_BITS-1:0] w_tag [SLOTS+1];

	logic [TYPE_W-1:0] e_type [SLOTS+1];
	logic [PRI_W-1:0]  e_pri  [SLOTS+1];
	logic [DIR_W-1:0]  e_dir  [SLOTS+1];
	logic [TAG_BITS-1:0] e_tag [SLOTS+1];

	assign w_have[0] = 1'b0;
	assign w_pri[0]  = '0;
	assign w_idx[0]  = '0;
	assign w_cnt[0]  = '0;
	assign w_type[0] = '0;
	assign w_tag[0]  = '0;

	// beyond the last slot, only read on removal past the fill line
	assign e_type[SLOTS] = '0;
	assign e_pri[SLOTS]  = '0;
	assign e_dir[SLOTS]  = DIR_NONE;
	assign e_tag[SLOTS]  = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		dfpq_cell #(
			.SLOTS    (SLOTS),
			.TAG_BITS (TAG_BITS),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.fill       (fill_q),
			.best_idx   (w_idx[SLOTS]),
			.search_dir (dir_q),
			.new_type   (type_q),
			.new_pri    (pri_q),
			.new_dir    (dir_q),
			.new_tag    (tag_q),
			.nxt_type   (e_type[i+1]),
			.nxt_pri    (e_pri[i+1]),
			.nxt_dir    (e_dir[i+1]),
			.nxt_tag    (e_tag[i+1]),
			.ent_type_q (e_type[i]),
			.ent_pri_q  (e_pri[i]),
			.ent_dir_q  (e_dir[i]),
			.ent_tag_q  (e_tag[i]),
			.w_have     (w_have[i]),
			.w_pri      (w_pri[i]),
			.w_idx      (w_idx[i]),
			.w_cnt      (w_cnt[i]),
			.w_type     (w_type[i]),
			.w_tag      (w_tag[i]),
			.wo_have_q  (w_have[i+1]),
			.wo_pri_q   (w_pri[i+1]),
			.wo_idx_q   (w_idx[i+1]),
			.wo_cnt_q   (w_cnt[i+1]),
			.wo_type_q  (w_type[i+1]),
			.wo_tag_q   (w_tag[i+1])
		);
	end

	logic full;
	assign full      = fill_q == FULL_CNT;
	assign scan_last = scan_q == LAST_IDX;
	assign out_free  = !out_valid || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: if (scan_last) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_SCAN: in_stall = 1'b1;
			ST_DONE: finish   = out_free;
			default: in_stall = 1'b1;
		endcase
		ctl.append = finish && (cmd_q == CMD_ADD) && !full;
		ctl.remove = finish && (cmd_q == CMD_SELECT) && w_have[SLOTS];
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) scan_q <= '0;
			else if (state_q == ST_SCAN) scan_q <= scan_q + IDX_W'(1);
			if (ctl.append) fill_q <= fill_q + CNT_W'(1);
			else if (ctl.remove) fill_q <= fill_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			type_q <= good_type;
			pri_q  <= priority_req;
			// direction seven folds onto none
			dir_q  <= (direction > DIR_NONE) ? DIR_NONE : direction;
			tag_q  <= item_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (cmd_q == CMD_ADD) begin
				status           <= full ? STATUS_FULL : STATUS_OK;
				found            <= 1'b0;
				out_good_type    <= '0;
				out_item_tag     <= '0;
				notify_direction <= full ? DIR_NONE : dir_q;
				// an appended item carries the counted direction; a full buffer adds none
				count_for_direction <= w_cnt[SLOTS] + CNT_W'(!full);
				occupancy        <= fill_q + CNT_W'(!full);
			end else begin
				status           <= w_have[SLOTS] ? STATUS_OK : STATUS_EMPTY;
				found            <= w_have[SLOTS];
				out_good_type    <= w_have[SLOTS] ? w_type[SLOTS] : '0;
				out_item_tag     <= w_have[SLOTS] ? w_tag[SLOTS] : '0;
				notify_direction <= DIR_NONE;
				count_for_direction <= w_cnt[SLOTS] - CNT_W'(w_have[SLOTS]);
				occupancy        <= fill_q - CNT_W'(w_have[SLOTS]);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/dfpq_cell.sv @@
`default_nettype none
module dfpq_cell #(
	parameter int SLOTS    = 8,
	parameter int TAG_BITS = 16,
	parameter int IDX      = 0
) (
	input  wire                          clk,
	input  wire dfpq_pkg::slot_ctl_t     ctl,
	input  wire [$clog2(SLOTS+1)-1:0]    fill,
	input  wire [$clog2(SLOTS)-1:0]      best_idx,
	input  wire [dfpq_pkg::DIR_W-1:0]    search_dir,
	// item written on append
	input  wire [dfpq_pkg::TYPE_W-1:0]   new_type,
	input  wire [dfpq_pkg::PRI_W-1:0]    new_pri,
	input  wire [dfpq_pkg::DIR_W-1:0]    new_dir,
	input  wire [TAG_BITS-1:0]           new_tag,
	// entry of the next cell, taken on removal
	input  wire [dfpq_pkg::TYPE_W-1:0]   nxt_type,
	input  wire [dfpq_pkg::PRI_W-1:0]    nxt_pri,
	input  wire [dfpq_pkg::DIR_W-1:0]    nxt_dir,
	input  wire [TAG_BITS-1:0]           nxt_tag,
	// own entry, handed to the previous cell
	output logic [dfpq_pkg::TYPE_W-1:0]  ent_type_q,
	output logic [dfpq_pkg::PRI_W-1:0]   ent_pri_q,
	output logic [dfpq_pkg::DIR_W-1:0]   ent_dir_q,
	output logic [TAG_BITS-1:0]          ent_tag_q,
	// search wave from the previous cell
	input  wire                          w_have,
	input  wire [dfpq_pkg::PRI_W-1:0]    w_pri,
	input  wire [$clog2(SLOTS)-1:0]      w_idx,
	input  wire [$clog2(SLOTS+1)-1:0]    w_cnt,
	input  wire [dfpq_pkg::TYPE_W-1:0]   w_type,
	input  wire [TAG_BITS-1:0]           w_tag,
	// search wave to the next cell
	output logic                         wo_have_q,
	output logic [dfpq_pkg::PRI_W-1:0]   wo_pri_q,
	output logic [$clog2(SLOTS)-1:0]     wo_idx_q,
	output logic [$clog2(SLOTS+1)-1:0]   wo_cnt_q,
	output logic [dfpq_pkg::TYPE_W-1:0]  wo_type_q,
	output logic [TAG_BITS-1:0]          wo_tag_q
);
	import dfpq_pkg::*;

	localparam int CNT_W = $clog2(SLOTS+1);
	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic live;
	logic match;
	logic pick;

	always_comb begin
		live  = MY_POS < fill;
		match = live && (ent_dir_q == search_dir);
		// strict compare keeps the earliest item on a tie
		pick  = match && (search_dir != DIR_NONE) && (!w_have || (ent_pri_q < w_pri));
	end

	always_ff @(posedge clk) begin
		wo_have_q <= w_have | pick;
		wo_pri_q  <= pick ? ent_pri_q  : w_pri;
		wo_idx_q  <= pick ? MY_IDX     : w_idx;
		wo_type_q <= pick ? ent_type_q : w_type;
		wo_tag_q  <= pick ? ent_tag_q  : w_tag;
		wo_cnt_q  <= w_cnt + CNT_W'(match);
	end

	always_ff @(posedge clk) begin
		if (ctl.append && (MY_POS == fill)) begin
			ent_type_q <= new_type;
			ent_pri_q  <= new_pri;
			ent_dir_q  <= new_dir;
			ent_tag_q  <= new_tag;
		end else if (ctl.remove && (MY_IDX >= best_idx)) begin
			ent_type_q <= nxt_type;
			ent_pri_q  <= nxt_pri;
			ent_dir_q  <= nxt_dir;
			ent_tag_q  <= nxt_tag;
		end
	end

endmodule
`default_nettype wire

@@ bench/direction_filtered_priority_queue_test.sv @@
`timescale 1ns / 1ps
module direction_filtered_priority_queue_test;
	import dfpq_pkg::*;

	localparam int SLOTS    = 8;
	localparam int TAG_BITS = 16;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int ITEMS    = 750;
	localparam int ROAD_MAX = 5;
	localparam logic [DIR_W-1:0] DIR_ALIAS = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                command;
	logic [TYPE_W-1:0]   good_type;
	logic [PRI_W-1:0]    priority_req;
	logic [DIR_W-1:0]    direction;
	logic [TAG_BITS-1:0] item_tag;
	logic                out_valid;
	logic                out_stall;
	logic [STAT_W-1:0]   status;
	logic                found;
	logic [TYPE_W-1:0]   out_good_type;
	logic [TAG_BITS-1:0] out_item_tag;
	logic [DIR_W-1:0]    notify_direction;
	logic [CNT_W-1:0]    count_for_direction;
	logic [CNT_W-1:0]    occupancy;

	direction_filtered_priority_queue #(
		.SLOTS(SLOTS),
		.TAG_BITS(TAG_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.good_type(good_type),
		.priority_req(priority_req),
		.direction(direction),
		.item_tag(item_tag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found(found),
		.out_good_type(out_good_type),
		.out_item_tag(out_item_tag),
		.notify_direction(notify_direction),
		.count_for_direction(count_for_direction),
		.occupancy(occupancy)
	);

	typedef struct {
		logic [TYPE_W-1:0]   gtype;
		logic [PRI_W-1:0]    pri;
		logic [DIR_W-1:0]    dir;
		logic [TAG_BITS-1:0] tag;
	} held_item_t;

	typedef struct {
		logic [STAT_W-1:0]   status;
		logic                found;
		logic [TYPE_W-1:0]   gtype;
		logic [TAG_BITS-1:0] tag;
		logic [DIR_W-1:0]    notify;
		logic [CNT_W-1:0]    count;
		logic [CNT_W-1:0]    occ;
	} queue_result_t;

	typedef struct {
		logic          cmd;
		held_item_t    item;
		bit            typed;
		queue_result_t want;
	} stim_row_t;

	held_item_t    shelf[SLOTS];
	int            shelf_fill;
	queue_result_t awaited_results[$];
	stim_row_t     plan[$];
	stim_row_t     cur_row;

	int beats_in;
	int results_in;
	int errors;
	int n_add, n_select, n_hit, n_drop, n_miss;

	// shadow of the buffer: append or select-and-compact, then count
	function automatic queue_result_t select_or_append(input logic cmd, input held_item_t it);
		queue_result_t r;
		logic [DIR_W-1:0] d;
		int best;
		bit have;
		int n;
		d = (it.dir > DIR_NONE) ? DIR_NONE : it.dir;
		r.status = STATUS_OK;
		r.found  = 1'b0;
		r.gtype  = '0;
		r.tag    = '0;
		r.notify = DIR_NONE;
		have = 1'b0;
		best = 0;
		if (cmd == CMD_ADD) begin
			if (shelf_fill >= SLOTS) begin
				r.status = STATUS_FULL;
			end else begin
				shelf[shelf_fill] = it;
				shelf[shelf_fill].dir = d;
				shelf_fill++;
				r.notify = d;
			end
		end else begin
			if (d != DIR_NONE) begin
				for (int i = 0; i < shelf_fill; i++) begin
					if (shelf[i].dir == d && (!have || shelf[i].pri < shelf[best].pri)) begin
						best = i;
						have = 1'b1;
					end
				end
			end
			if (have) begin
				r.found = 1'b1;
				r.gtype = shelf[best].gtype;
				r.tag   = shelf[best].tag;
				for (int i = best; i + 1 < shelf_fill; i++)
					shelf[i] = shelf[i + 1];
				shelf_fill--;
			end else begin
				r.status = STATUS_EMPTY;
			end
		end
		n = 0;
		for (int i = 0; i < shelf_fill; i++)
			if (shelf[i].dir == d)
				n++;
		r.count = CNT_W'(n);
		r.occ   = CNT_W'(shelf_fill);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= 40)
			$display("mismatch at result %0d: %s got %0h expected %0h",
				results_in, what, got, want);
	endtask

	task automatic check_field(input string what, input longint got, input longint want);
		if (got != want)
			flag_mismatch(what, got, want);
	endtask

	function automatic stim_row_t make_row(input logic cmd, input int gt, input int pri,
			input int dir, input int tag);
		stim_row_t row;
		row.cmd        = cmd;
		row.item.gtype = TYPE_W'(gt);
		row.item.pri   = PRI_W'(pri);
		row.item.dir   = DIR_W'(dir);
		row.item.tag   = TAG_BITS'(tag);
		row.typed      = 1'b0;
		row.want       = '{STATUS_OK, 1'b0, '0, '0, DIR_NONE, '0, '0};
		return row;
	endfunction

	task automatic add_row(input logic cmd, input int gt, input int pri, input int dir,
			input int tag);
		plan.insert(plan.size(), make_row(cmd, gt, pri, dir, tag));
	endtask

	task automatic add_checked_row(input logic cmd, input int gt, input int pri, input int dir,
			input int tag, input logic [STAT_W-1:0] st, input logic fnd, input int otype,
			input int otag, input logic [DIR_W-1:0] ntf, input int cnt, input int occ);
		stim_row_t row;
		row = make_row(cmd, gt, pri, dir, tag);
		row.typed = 1'b1;
		row.want.status = st;
		row.want.found  = fnd;
		row.want.gtype  = TYPE_W'(otype);
		row.want.tag    = TAG_BITS'(otag);
		row.want.notify = ntf;
		row.want.count  = CNT_W'(cnt);
		row.want.occ    = CNT_W'(occ);
		plan.insert(plan.size(), row);
	endtask

	// phases: 0 fill up, 1 drain, 2 mixed, 3 hammer a full buffer
	function automatic stim_row_t random_row(input int k);
		stim_row_t row;
		int phase;
		int add_pct;
		int pick;
		int d;
		phase = (k / 40) % 4;
		case (phase)
			0: add_pct = 75;
			1: add_pct = 25;
			2: add_pct = 50;
			default: add_pct = 90;
		endcase
		row = make_row(CMD_ADD, int'($urandom_range(0, 63)), 0, 0, int'($urandom()));
		if ($urandom_range(0, 1) == 0)
			row.item.pri = PRI_W'($urandom_range(0, 63));
		else
			row.item.pri = PRI_W'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < add_pct) begin
			if ($urandom_range(0, 99) < 85)
				row.item.dir = DIR_W'($urandom_range(0, ROAD_MAX));
			else
				row.item.dir = $urandom_range(0, 1) ? DIR_ALIAS : DIR_NONE;
		end else begin
			row.cmd = CMD_SELECT;
			pick = int'($urandom_range(0, 99));
			d = int'($urandom_range(0, ROAD_MAX));
			if (pick < 80 && shelf_fill > 0) begin
				d = int'(shelf[$urandom_range(0, shelf_fill - 1)].dir);
				if (d > ROAD_MAX)
					d = int'($urandom_range(0, ROAD_MAX));
			end else if (pick >= 92) begin
				d = int'($urandom_range(0, 1) ? DIR_ALIAS : DIR_NONE);
			end
			row.item.dir = DIR_W'(d);
		end
		return row;
	endfunction

	task automatic offer_item(input stim_row_t row, input bit may_idle);
		int mark;
		int gap;
		if (may_idle && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		cur_row = row;
		command      <= row.cmd;
		good_type    <= row.item.gtype;
		priority_req <= row.item.pri;
		direction    <= row.item.dir;
		item_tag     <= row.item.tag;
		in_valid     <= 1'b1;
		mark = beats_in;
		do @(negedge clk); while (beats_in == mark);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// accepted input beat: predict and queue the result
	always @(posedge clk) begin : take_beat
		held_item_t it;
		queue_result_t r;
		if (arst_n && in_valid && !in_stall) begin
			it.gtype = good_type;
			it.pri   = priority_req;
			it.dir   = direction;
			it.tag   = item_tag;
			r = select_or_append(command, it);
			if (command == CMD_ADD) n_add++;
			else n_select++;
			if (r.found) n_hit++;
			if (r.status == STATUS_FULL) n_drop++;
			if (r.status == STATUS_EMPTY) n_miss++;
			if (cur_row.typed)
				r = cur_row.want;
			awaited_results.insert(awaited_results.size(), r);
			beats_in++;
		end
	end

	always @(posedge clk) begin : take_result
		queue_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("unexpected result beat", longint'(status), longint'(0));
			end else begin
				w = awaited_results.pop_front();
				check_field("status", longint'(status), longint'(w.status));
				check_field("found", longint'(found), longint'(w.found));
				check_field("out_good_type", longint'(out_good_type), longint'(w.gtype));
				check_field("out_item_tag", longint'(out_item_tag), longint'(w.tag));
				check_field("notify_direction", longint'(notify_direction),
					longint'(w.notify));
				check_field("count_for_direction", longint'(count_for_direction),
					longint'(w.count));
				check_field("occupancy", longint'(occupancy), longint'(w.occ));
			end
			results_in++;
		end
	end

	// receiver: sparse random stalls, one long hold-off, one stall-free window
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_in >= 150) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_in >= 400 && results_in < 550) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 9);
			end
		end
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", awaited_results.size());
		$display("direction_filtered_priority_queue_test NOT OK");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_ADD;
		good_type    = '0;
		priority_req = '0;
		direction    = '0;
		item_tag     = '0;
		shelf_fill   = 0;
		beats_in     = 0;
		results_in   = 0;
		errors       = 0;
		n_add = 0; n_select = 0; n_hit = 0; n_drop = 0; n_miss = 0;

		// empty buffer, extremes, direction seven, full buffer, ties, no-match selects
		add_checked_row(CMD_SELECT, 0, 0, 0, 0, STATUS_EMPTY, 1'b0, 0, 0, DIR_NONE, 0, 0);
		add_checked_row(CMD_SELECT, 63, 63, DIR_NONE, 'hffff,
			STATUS_EMPTY, 1'b0, 0, 0, DIR_NONE, 0, 0);
		add_checked_row(CMD_ADD, 63, 63, 5, 'hffff, STATUS_OK, 1'b0, 0, 0, 5, 1, 1);
		add_checked_row(CMD_ADD, 0, 0, 0, 0, STATUS_OK, 1'b0, 0, 0, 0, 1, 2);
		add_checked_row(CMD_ADD, 7, 20, DIR_NONE, 'h00aa, STATUS_OK, 1'b0, 0, 0, DIR_NONE, 1, 3);
		add_checked_row(CMD_ADD, 9, 20, DIR_ALIAS, 'h5555, STATUS_OK, 1'b0, 0, 0, DIR_NONE, 2, 4);
		add_row(CMD_ADD, 21, 0, 0, 'h1234);
		add_row(CMD_ADD, 33, 10, 0, 'haaaa);
		add_row(CMD_ADD, 42, 31, 3, 'h0f0f);
		add_row(CMD_ADD, 1, 63, 0, 'h8001);
		add_checked_row(CMD_ADD, 2, 5, 2, 'h7777, STATUS_FULL, 1'b0, 0, 0, DIR_NONE, 0, 8);
		add_checked_row(CMD_ADD, 3, 5, DIR_ALIAS, 'h0001,
			STATUS_FULL, 1'b0, 0, 0, DIR_NONE, 2, 8);
		add_row(CMD_SELECT, 63, 63, 0, 'hffff);
		add_row(CMD_SELECT, 0, 0, 0, 0);
		add_row(CMD_SELECT, 0, 0, DIR_NONE, 0);
		add_row(CMD_SELECT, 63, 0, DIR_ALIAS, 'hffff);
		add_row(CMD_SELECT, 0, 0, 4, 0);
		add_row(CMD_SELECT, 0, 0, 5, 0);
		add_row(CMD_SELECT, 0, 0, 0, 0);
		add_row(CMD_SELECT, 0, 0, 3, 0);
		add_row(CMD_SELECT, 0, 0, 0, 0);
		add_row(CMD_SELECT, 0, 0, 0, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			offer_item(plan[i], 1'b1);
		wait_drained();

		for (int k = 0; k < ITEMS; k++) begin
			if (k == 500)
				wait_drained();
			offer_item(random_row(k), !(k >= 300 && k < 450));
		end
		wait_drained();
		repeat (SLOTS * 4) @(negedge clk);

		$display("covered %0d beats: %0d adds (%0d dropped full), %0d selects",
			beats_in, n_add, n_drop, n_select);
		$display("selects: %0d returned an item, %0d found nothing; %0d results checked",
			n_hit, n_miss, results_in);
		if (errors == 0)
			$display("direction_filtered_priority_queue_test OK");
		else
			$display("direction_filtered_priority_queue_test NOT OK");
		$finish;
	end

endmodule

@@ direction_filtered_priority_queue.f @@
hdl/dfpq_pkg.sv
hdl/dfpq_cell.sv
hdl/direction_filtered_priority_queue.sv
bench/direction_filtered_priority_queue_test.sv
